// ===== hw/rtl/bgm_pkg.sv =====
// Shared types and constants of the Gaussian background model.
package bgm_pkg;

  typedef enum logic [1:0] {
    ACT_LEARN    = 2'd0,
    ACT_FINALIZE = 2'd1,
    ACT_SEGMENT  = 2'd2,
    ACT_UPDATE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    UPD_NONE  = 2'd0,
    UPD_SHORT = 2'd1,
    UPD_LONG  = 2'd2
  } upd_kind_e;

  typedef enum logic [2:0] {
    REG_LEARN_FRAMES = 3'd0,
    REG_K_FACTOR     = 3'd1,
    REG_ALPHA_WEIGHT = 3'd2,
    REG_SHORT_PERIOD = 3'd3,
    REG_LONG_PERIOD  = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    FR_IDLE,
    FR_MOD
  } front_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_CALC,
    BK_DIV,
    BK_FIN,
    BK_DONE
  } back_state_e;

  localparam int unsigned CHANNELS     = 3;
  localparam int unsigned MEAN_W       = 24;
  localparam int unsigned VAR_W        = 26;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned DIV_STEPS    = 26;
  localparam int unsigned MOD_BITS     = 4;
  localparam int unsigned MOD_CYCLES   = 32 / MOD_BITS;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned BLEND_ROUND  = 32768;

  localparam logic [MEAN_W-1:0] MEAN_MAX = '1;
  localparam logic [VAR_W-1:0]  VAR_MAX  = '1;

  localparam logic [9:0]  LF_RESET    = 10'd100;
  localparam logic [15:0] K_RESET     = 16'd10240;
  localparam logic [15:0] ALPHA_RESET = 16'd655;
  localparam logic [15:0] SHORT_RESET = 16'd1;
  localparam logic [15:0] LONG_RESET  = 16'd0;

  typedef struct packed {
    action_e     action;
    logic [15:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        mask_bit;
    logic [31:0] frame_number;
  } in_item_t;

  typedef struct packed {
    logic       foreground;
    logic [1:0] update_kind;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    action_e                    action;
    logic [15:0]                pixel;
    logic                       in_range;
    logic                       fresh;
    logic [CHANNELS-1:0][7:0]   px;
    logic [CHANNELS-1:0][15:0]  sq;
    logic                       wr;
    upd_kind_e                  kind;
  } work_t;

  typedef struct packed {
    logic [15:0] short_period;
    logic [15:0] long_period;
  } period_cfg_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic [16:0] inv_alpha;
    logic [9:0]  n;
    logic [19:0] n2;
    logic [31:0] k2;
  } back_cfg_t;

endpackage

// ===== hw/rtl/bgm_if.sv =====
// Handshake channels: input items, result items and configuration writes.
interface bgm_in_if;
  logic               valid;
  logic               ready;
  bgm_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bgm_out_if;
  logic               valid;
  logic               ready;
  bgm_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bgm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bgm_pkg::CFG_IDX_W-1:0]      index;
  logic [bgm_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/bgm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bgm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bgm_front.sv =====
// Front end: accepts items, squares intensities, resolves update periods.
module bgm_front #(
  parameter int unsigned PIXEL_COUNT = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bgm_in_if.sink               in_i,
  input  bgm_pkg::period_cfg_t per_i,
  input  logic                 full_i,
  output logic                 push_o,
  output bgm_pkg::work_t       push_data_o
);

  localparam int unsigned CH = bgm_pkg::CHANNELS;

  bgm_pkg::front_state_e state_q, state_d;
  bgm_pkg::work_t        item;
  bgm_pkg::work_t        hold_q;
  bgm_pkg::work_t        hold_done;
  logic [31:0]           frame_q;
  logic [15:0]           rl_q, rs_q, rl_n, rs_n;
  logic [3:0]            cnt_q;
  logic                  mask_q;
  logic                  accept;
  logic                  needs_mod;
  logic                  mod_done;

  assign accept   = in_i.valid && in_i.ready;
  assign mod_done = (cnt_q == 4'(bgm_pkg::MOD_CYCLES));

  always_comb begin
    item          = '0;
    item.action   = in_i.payload.action;
    item.pixel    = in_i.payload.pixel_index;
    item.in_range = (32'(in_i.payload.pixel_index) < 32'(PIXEL_COUNT));
    item.fresh    = (in_i.payload.frame_number == 32'd0);
    item.px[0]    = in_i.payload.red;
    item.px[1]    = in_i.payload.green;
    item.px[2]    = in_i.payload.blue;
    for (int c = 0; c < CH; c++) begin
      item.sq[c] = 16'(item.px[c]) * 16'(item.px[c]);
    end
    item.wr   = 1'b0;
    item.kind = bgm_pkg::UPD_NONE;
  end

  assign needs_mod = (in_i.payload.action == bgm_pkg::ACT_UPDATE) && item.in_range &&
                     ((per_i.long_period != 16'd0) || (per_i.short_period != 16'd0));

  // restoring remainder, MOD_BITS frame bits per step, both periods in parallel
  always_comb begin
    logic [16:0] tl, ts;
    rl_n = rl_q;
    rs_n = rs_q;
    for (int i = 0; i < bgm_pkg::MOD_BITS; i++) begin
      tl = {rl_n, frame_q[31-i]};
      ts = {rs_n, frame_q[31-i]};
      if (tl >= {1'b0, per_i.long_period}) begin
        tl = tl - {1'b0, per_i.long_period};
      end
      if (ts >= {1'b0, per_i.short_period}) begin
        ts = ts - {1'b0, per_i.short_period};
      end
      rl_n = tl[15:0];
      rs_n = ts[15:0];
    end
  end

  always_comb begin
    hold_done = hold_q;
    if ((per_i.long_period != 16'd0) && (rl_q == 16'd0)) begin
      hold_done.kind = bgm_pkg::UPD_LONG;
      hold_done.wr   = 1'b1;
    end else if ((per_i.short_period != 16'd0) && (rs_q == 16'd0)) begin
      hold_done.kind = bgm_pkg::UPD_SHORT;
      hold_done.wr   = !mask_q;
    end else begin
      hold_done.kind = bgm_pkg::UPD_NONE;
      hold_done.wr   = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bgm_pkg::FR_IDLE: begin
        if (accept && needs_mod) state_d = bgm_pkg::FR_MOD;
      end
      bgm_pkg::FR_MOD: begin
        if (mod_done && !full_i) state_d = bgm_pkg::FR_IDLE;
      end
      default: state_d = bgm_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready  = 1'b0;
    push_o      = 1'b0;
    push_data_o = item;
    unique case (state_q)
      bgm_pkg::FR_IDLE: begin
        in_i.ready = !full_i;
        push_o     = accept && !needs_mod;
      end
      bgm_pkg::FR_MOD: begin
        push_o      = mod_done && !full_i;
        push_data_o = hold_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bgm_pkg::FR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept && needs_mod) begin
        cnt_q <= '0;
      end else if ((state_q == bgm_pkg::FR_MOD) && !mod_done) begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && needs_mod) begin
      hold_q  <= item;
      frame_q <= in_i.payload.frame_number;
      mask_q  <= in_i.payload.mask_bit;
      rl_q    <= '0;
      rs_q    <= '0;
    end else if ((state_q == bgm_pkg::FR_MOD) && !mod_done) begin
      frame_q <= {frame_q[31-bgm_pkg::MOD_BITS:0], {bgm_pkg::MOD_BITS{1'b0}}};
      rl_q    <= rl_n;
      rs_q    <= rs_n;
    end
  end

endmodule

// ===== hw/rtl/bgm_queue.sv =====
// Short FIFO of classified items between front and back end.
module bgm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bgm_pkg::work_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output bgm_pkg::work_t head_o,
  output logic           empty_o
);

  localparam int unsigned AW = $clog2(bgm_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = AW + 1;

  bgm_pkg::work_t mem_q [bgm_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wptr_q, rptr_q;
  logic [CW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CW'(bgm_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + AW'(1);
      if (pop_i)  rptr_q <= rptr_q + AW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

endmodule

// ===== hw/rtl/bgm_back.sv =====
// Back end: memory read, per-channel arithmetic, divider, write-back, result register.
module bgm_back #(
  parameter int unsigned PIXEL_COUNT = 65536
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  bgm_pkg::work_t                                    head_i,
  input  logic                                              empty_i,
  output logic                                              pop_o,
  input  bgm_pkg::back_cfg_t                                cfg_i,
  output logic                                              mem_re_o,
  output logic                                              mem_we_o,
  output logic [$clog2(PIXEL_COUNT)-1:0]                    mem_addr_o,
  output logic [bgm_pkg::CHANNELS*bgm_pkg::MEAN_W-1:0]      mean_wdata_o,
  output logic [bgm_pkg::CHANNELS*bgm_pkg::VAR_W-1:0]       var_wdata_o,
  input  logic [bgm_pkg::CHANNELS*bgm_pkg::MEAN_W-1:0]      mean_rdata_i,
  input  logic [bgm_pkg::CHANNELS*bgm_pkg::VAR_W-1:0]       var_rdata_i,
  bgm_out_if.source                                         out_o
);

  localparam int unsigned CH = bgm_pkg::CHANNELS;
  localparam int unsigned MW = bgm_pkg::MEAN_W;
  localparam int unsigned VW = bgm_pkg::VAR_W;
  localparam int unsigned AW = $clog2(PIXEL_COUNT);

  bgm_pkg::back_state_e state_q, state_d;
  bgm_pkg::work_t       w_q;
  bgm_pkg::out_item_t   out_q;
  logic                 out_valid_q;
  logic                 fg_q;
  logic [4:0]           cnt_q;
  logic                 need;
  logic                 load;
  logic                 div_last;

  logic [47:0] a_q [CH];
  logic [57:0] b_q [CH];
  logic [31:0] c_q [CH];
  logic [23:0] d_q [CH];
  logic [MW-1:0] m_q [CH];
  logic [9:0]  mr_q [CH];
  logic [25:0] md_q [CH];
  logic [19:0] vr_q [CH];
  logic [25:0] vd_q [CH];
  logic [CH-1:0] msat_q, vsat_q, vzero_q;

  logic [MW-1:0] old_m [CH];
  logic [VW-1:0] old_v [CH];
  logic [MW-1:0] base_m [CH];
  logic [VW-1:0] base_v [CH];
  logic [MW-1:0] dabs [CH];
  logic [35:0]   diff [CH];
  logic [CH-1:0] pos, msat_n, vsat_n, seg_hit;
  logic [9:0]    mr_n [CH];
  logic [25:0]   md_n [CH];
  logic [19:0]   vr_n [CH];
  logic [25:0]   vd_n [CH];
  logic [CH-1:0][MW-1:0] learn_m, upd_m, fin_m;
  logic [CH-1:0][VW-1:0] learn_v, upd_v, fin_v;

  assign need     = head_i.in_range &&
                    ((head_i.action != bgm_pkg::ACT_UPDATE) || head_i.wr);
  assign load     = !out_valid_q || out_o.ready;
  assign div_last = (cnt_q == 5'(bgm_pkg::DIV_STEPS - 1));

  always_comb begin
    logic [MW-1:0] ipx;
    logic [41:0]   usm;
    logic [43:0]   usv;
    logic [10:0]   mrem;
    logic [20:0]   vrem;
    for (int c = 0; c < CH; c++) begin
      old_m[c]  = mean_rdata_i[c*MW +: MW];
      old_v[c]  = var_rdata_i[c*VW +: VW];
      base_m[c] = w_q.fresh ? '0 : old_m[c];
      base_v[c] = w_q.fresh ? '0 : old_v[c];
      ipx       = {w_q.px[c], 16'b0};
      dabs[c]   = (old_m[c] >= ipx) ? (old_m[c] - ipx) : (ipx - old_m[c]);

      learn_m[c] = a_q[c][MW] ? bgm_pkg::MEAN_MAX : a_q[c][MW-1:0];
      learn_v[c] = b_q[c][VW] ? bgm_pkg::VAR_MAX : b_q[c][VW-1:0];

      usm = 42'(a_q[c][40:0]) + 42'({d_q[c], 16'b0}) + 42'(bgm_pkg::BLEND_ROUND);
      usv = 44'(b_q[c][42:0]) + 44'({c_q[c], 10'b0}) + 44'(bgm_pkg::BLEND_ROUND);
      upd_m[c] = usm[39:16];
      upd_v[c] = usv[41:16];

      // d^2 * 4 against k^2 (Q8.24) * var (Q16.10)
      seg_hit[c] = (58'({a_q[c], 2'b0}) >= b_q[c]);

      // finalize: n*sumsq - sum^2, and saturation of both quotients
      pos[c]    = (48'(b_q[c][35:0]) > a_q[c]);
      diff[c]   = b_q[c][35:0] - a_q[c][35:0];
      vsat_n[c] = pos[c] && (diff[c] >= {cfg_i.n2, 16'b0});
      msat_n[c] = (m_q[c] >= 24'({cfg_i.n, 8'b0}));

      mrem    = {mr_q[c], md_q[c][25]};
      md_n[c] = {md_q[c][24:0], (mrem >= {1'b0, cfg_i.n})};
      mr_n[c] = (mrem >= {1'b0, cfg_i.n}) ? 10'(mrem - {1'b0, cfg_i.n}) : mrem[9:0];
      vrem    = {vr_q[c], vd_q[c][25]};
      vd_n[c] = {vd_q[c][24:0], (vrem >= {1'b0, cfg_i.n2})};
      vr_n[c] = (vrem >= {1'b0, cfg_i.n2}) ? 20'(vrem - {1'b0, cfg_i.n2}) : vrem[19:0];

      fin_m[c] = msat_q[c] ? bgm_pkg::MEAN_MAX : md_q[c][MW-1:0];
      fin_v[c] = vzero_q[c] ? '0 : (vsat_q[c] ? bgm_pkg::VAR_MAX : vd_q[c]);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bgm_pkg::BK_IDLE: begin
        if (!empty_i) state_d = need ? bgm_pkg::BK_READ : bgm_pkg::BK_DONE;
      end
      bgm_pkg::BK_READ: state_d = bgm_pkg::BK_CALC;
      bgm_pkg::BK_CALC: begin
        state_d = (w_q.action == bgm_pkg::ACT_FINALIZE) ? bgm_pkg::BK_DIV : bgm_pkg::BK_DONE;
      end
      bgm_pkg::BK_DIV: begin
        if (div_last) state_d = bgm_pkg::BK_FIN;
      end
      bgm_pkg::BK_FIN:  state_d = bgm_pkg::BK_DONE;
      bgm_pkg::BK_DONE: begin
        if (load) state_d = bgm_pkg::BK_IDLE;
      end
      default: state_d = bgm_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o        = 1'b0;
    mem_re_o     = 1'b0;
    mem_we_o     = 1'b0;
    mem_addr_o   = AW'(w_q.pixel);
    mean_wdata_o = learn_m;
    var_wdata_o  = learn_v;
    unique case (state_q)
      bgm_pkg::BK_IDLE: begin
        pop_o      = !empty_i;
        mem_re_o   = !empty_i && need;
        mem_addr_o = AW'(head_i.pixel);
      end
      bgm_pkg::BK_CALC: begin
        if (w_q.action == bgm_pkg::ACT_LEARN) begin
          mem_we_o = 1'b1;
        end else if (w_q.action == bgm_pkg::ACT_UPDATE) begin
          mem_we_o     = 1'b1;
          mean_wdata_o = upd_m;
          var_wdata_o  = upd_v;
        end
      end
      bgm_pkg::BK_FIN: begin
        mem_we_o     = 1'b1;
        mean_wdata_o = fin_m;
        var_wdata_o  = fin_v;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bgm_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == bgm_pkg::BK_DONE) && load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == bgm_pkg::BK_CALC) begin
        cnt_q <= '0;
      end else if (state_q == bgm_pkg::BK_DIV) begin
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == bgm_pkg::BK_DONE) && load) begin
      out_q.foreground  <= fg_q;
      out_q.update_kind <= w_q.kind;
    end
    unique case (state_q)
      bgm_pkg::BK_IDLE: begin
        if (!empty_i) w_q <= head_i;
        fg_q <= 1'b0;
      end
      bgm_pkg::BK_READ: begin
        for (int c = 0; c < CH; c++) begin
          m_q[c] <= old_m[c];
          unique case (w_q.action)
            bgm_pkg::ACT_LEARN: begin
              a_q[c] <= 48'(base_m[c]) + 48'(w_q.px[c]);
              b_q[c] <= 58'(base_v[c]) + 58'(w_q.sq[c]);
            end
            bgm_pkg::ACT_FINALIZE: begin
              a_q[c] <= 48'(old_m[c]) * 48'(old_m[c]);
              b_q[c] <= 58'(old_v[c]) * 58'(cfg_i.n);
            end
            bgm_pkg::ACT_SEGMENT: begin
              a_q[c] <= 48'(dabs[c]) * 48'(dabs[c]);
              b_q[c] <= 58'(cfg_i.k2) * 58'(old_v[c]);
            end
            bgm_pkg::ACT_UPDATE: begin
              a_q[c] <= 48'(old_m[c]) * 48'(cfg_i.inv_alpha);
              b_q[c] <= 58'(old_v[c]) * 58'(cfg_i.inv_alpha);
              c_q[c] <= 32'(w_q.sq[c]) * 32'(cfg_i.alpha);
              d_q[c] <= 24'(w_q.px[c]) * 24'(cfg_i.alpha);
            end
            default: ;
          endcase
        end
      end
      bgm_pkg::BK_CALC: begin
        if (w_q.action == bgm_pkg::ACT_SEGMENT) fg_q <= |seg_hit;
        for (int c = 0; c < CH; c++) begin
          // remainder starts with the bits above the 26 quotient bits
          mr_q[c]    <= m_q[c][19:10];
          md_q[c]    <= {m_q[c][9:0], 16'b0};
          vr_q[c]    <= diff[c][35:16];
          vd_q[c]    <= {diff[c][15:0], 10'b0};
          msat_q[c]  <= msat_n[c];
          vsat_q[c]  <= vsat_n[c];
          vzero_q[c] <= !pos[c];
        end
      end
      bgm_pkg::BK_DIV: begin
        for (int c = 0; c < CH; c++) begin
          mr_q[c] <= mr_n[c];
          md_q[c] <= md_n[c];
          vr_q[c] <= vr_n[c];
          vd_q[c] <= vd_n[c];
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

`ifndef SYNTH
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_re_o && mem_we_o)) else $error("read and write in the same cycle");
  a_read_before_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bgm_pkg::BK_READ) |-> $past(mem_re_o)) else $error("no read issued");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i) else $error("pop from empty queue");
  a_fin_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bgm_pkg::BK_FIN) |-> ($past(state_q) == bgm_pkg::BK_DIV))
    else $error("finalize write without divide");
`endif

endmodule

// ===== hw/rtl/gaussian_background_model.sv =====
// Top level: configuration registers, front end, queue, back end and model memories.
// Learn and writing updates read the model memories, compute and write back; segment only
// reads; finalize also runs the 26-step divider before its write. Items touching no memory
// (pixel out of range, update without write) skip the memories. Updates with a nonzero
// period first run the frame modulo, 4 frame bits per cycle, and the front end takes no new
// item meanwhile. One item at a time in the back end; a 2-entry queue decouples the sides.
// Reset clears control state and loads register defaults; model memories are not cleared.
module gaussian_background_model #(
  parameter int unsigned PIXEL_COUNT = 65536
) (
  input logic         clk_i,
  input logic         rst_ni,
  bgm_in_if.sink      in_i,
  bgm_out_if.source   out_o,
  bgm_cfg_if.sink     cfg_i
);

  localparam int unsigned AW = $clog2(PIXEL_COUNT);
  localparam int unsigned MWD = bgm_pkg::CHANNELS * bgm_pkg::MEAN_W;
  localparam int unsigned VWD = bgm_pkg::CHANNELS * bgm_pkg::VAR_W;

  logic [9:0]  lf_q;
  logic [15:0] k_q, alpha_q, short_q, long_q;
  logic [9:0]  n_q;
  logic [19:0] n2_q;
  logic [31:0] k2_q;
  logic [16:0] inv_alpha_q;
  logic [9:0]  n_w;

  bgm_pkg::period_cfg_t per;
  bgm_pkg::back_cfg_t   bcfg;
  bgm_pkg::work_t       push_data, head;
  logic                 push, full, pop, empty;
  logic                 mem_re, mem_we;
  logic [AW-1:0]        mem_addr;
  logic [MWD-1:0]       mean_wdata, mean_rdata;
  logic [VWD-1:0]       var_wdata, var_rdata;

  assign cfg_i.ready = 1'b1;
  assign n_w = (lf_q == 10'd0) ? 10'd1 : lf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lf_q        <= bgm_pkg::LF_RESET;
      k_q         <= bgm_pkg::K_RESET;
      alpha_q     <= bgm_pkg::ALPHA_RESET;
      short_q     <= bgm_pkg::SHORT_RESET;
      long_q      <= bgm_pkg::LONG_RESET;
      n_q         <= bgm_pkg::LF_RESET;
      n2_q        <= 20'(bgm_pkg::LF_RESET) * 20'(bgm_pkg::LF_RESET);
      k2_q        <= 32'(bgm_pkg::K_RESET) * 32'(bgm_pkg::K_RESET);
      inv_alpha_q <= 17'h10000 - 17'(bgm_pkg::ALPHA_RESET);
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          bgm_pkg::REG_LEARN_FRAMES: lf_q    <= cfg_i.data[9:0];
          bgm_pkg::REG_K_FACTOR:     k_q     <= cfg_i.data;
          bgm_pkg::REG_ALPHA_WEIGHT: alpha_q <= cfg_i.data;
          bgm_pkg::REG_SHORT_PERIOD: short_q <= cfg_i.data;
          bgm_pkg::REG_LONG_PERIOD:  long_q  <= cfg_i.data;
          default: ;
        endcase
      end
      n_q         <= n_w;
      n2_q        <= 20'(n_w) * 20'(n_w);
      k2_q        <= 32'(k_q) * 32'(k_q);
      inv_alpha_q <= 17'h10000 - 17'(alpha_q);
    end
  end

  assign per.short_period = short_q;
  assign per.long_period  = long_q;
  assign bcfg.alpha       = alpha_q;
  assign bcfg.inv_alpha   = inv_alpha_q;
  assign bcfg.n           = n_q;
  assign bcfg.n2          = n2_q;
  assign bcfg.k2          = k2_q;

  bgm_front #(.PIXEL_COUNT(PIXEL_COUNT)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .per_i       (per),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  bgm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  bgm_back #(.PIXEL_COUNT(PIXEL_COUNT)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .cfg_i        (bcfg),
    .mem_re_o     (mem_re),
    .mem_we_o     (mem_we),
    .mem_addr_o   (mem_addr),
    .mean_wdata_o (mean_wdata),
    .var_wdata_o  (var_wdata),
    .mean_rdata_i (mean_rdata),
    .var_rdata_i  (var_rdata),
    .out_o        (out_o)
  );

  bgm_ram #(.WIDTH(MWD), .DEPTH(PIXEL_COUNT)) u_mean_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mean_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mean_rdata)
  );

  bgm_ram #(.WIDTH(VWD), .DEPTH(PIXEL_COUNT)) u_var_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (var_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (var_rdata)
  );

endmodule

// ===== tb/gaussian_background_model_tb.sv =====
// Self-checking testbench of the Gaussian background model: directed table, then random frames.
`timescale 1ns / 1ps

module gaussian_background_model_tb;

  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned PHASE_ITEMS = 180;

  logic clk;
  logic rst_n;

  bgm_in_if  in_if ();
  bgm_out_if out_if ();
  bgm_cfg_if cfg_if ();

  gaussian_background_model dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow registers and model memories
  int unsigned lf_sh, k_sh, alpha_sh, short_sh, long_sh;
  longint unsigned mean_mem[int];
  longint unsigned var_mem[int];
  bit learned[int];

  bgm_pkg::out_item_t pending_results[$];
  int unsigned errors, n_items, n_results, n_fg, n_short, n_long, n_settings;
  bit calm, hold_req;
  logic [15:0] pix_pool[16];

  typedef struct {
    bit                 is_cfg;
    bgm_pkg::cfg_reg_e  reg_idx;
    logic [15:0]        value;
    bgm_pkg::action_e   act;
    logic [15:0]        pix;
    logic [7:0]         r, g, b;
    logic               mask;
    logic [31:0]        frame;
    bit                 typed;
    logic               fg;
    bgm_pkg::upd_kind_e kind;
  } dir_row_t;

  dir_row_t dir_tab[] = '{
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_LEARN, 16'd0, 0, 0, 0, 0, 32'd0,
      1, 0, bgm_pkg::UPD_NONE},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_LEARN, 16'hFFFF, 255, 255, 255, 1, 32'd0,
      1, 0, bgm_pkg::UPD_NONE},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_LEARN, 16'd0, 255, 128, 1, 0, 32'd7,
      1, 0, bgm_pkg::UPD_NONE},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_FINALIZE, 16'd0, 0, 0, 0, 0, 32'd0,
      1, 0, bgm_pkg::UPD_NONE},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_FINALIZE, 16'hFFFF, 0, 0, 0, 0, 32'd0,
      1, 0, bgm_pkg::UPD_NONE},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_SEGMENT, 16'd0, 17, 200, 3, 0, 32'd0,
      0, 0, bgm_pkg::UPD_NONE},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_SEGMENT, 16'hFFFF, 255, 255, 255, 0, 32'd0,
      0, 0, bgm_pkg::UPD_NONE},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_UPDATE, 16'd0, 90, 0, 255, 0, 32'hFFFFFFFF,
      1, 0, bgm_pkg::UPD_SHORT},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_UPDATE, 16'hFFFF, 1, 2, 3, 1, 32'd5,
      1, 0, bgm_pkg::UPD_SHORT},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_SEGMENT, 16'd0, 0, 0, 0, 0, 32'd0,
      0, 0, bgm_pkg::UPD_NONE},
    '{1, bgm_pkg::REG_LEARN_FRAMES, 16'd1, bgm_pkg::ACT_LEARN, 0, 0, 0, 0, 0, 0,
      0, 0, bgm_pkg::UPD_NONE},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_LEARN, 16'd2, 40, 40, 40, 0, 32'd0,
      1, 0, bgm_pkg::UPD_NONE},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_FINALIZE, 16'd2, 0, 0, 0, 0, 32'd0,
      1, 0, bgm_pkg::UPD_NONE},
    // equal to mean with zero variance: foreground
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_SEGMENT, 16'd2, 40, 40, 40, 0, 32'd0,
      1, 1, bgm_pkg::UPD_NONE},
    '{1, bgm_pkg::REG_LEARN_FRAMES, 16'd0, bgm_pkg::ACT_LEARN, 0, 0, 0, 0, 0, 0,
      0, 0, bgm_pkg::UPD_NONE},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_LEARN, 16'd3, 9, 9, 9, 0, 32'd0,
      1, 0, bgm_pkg::UPD_NONE},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_LEARN, 16'd3, 9, 9, 9, 0, 32'd1,
      1, 0, bgm_pkg::UPD_NONE},
    // n taken as 1, negative variance clamps to zero
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_FINALIZE, 16'd3, 0, 0, 0, 0, 32'd0,
      1, 0, bgm_pkg::UPD_NONE},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_SEGMENT, 16'd3, 18, 18, 18, 0, 32'd0,
      1, 1, bgm_pkg::UPD_NONE},
    '{1, bgm_pkg::REG_LONG_PERIOD, 16'd4, bgm_pkg::ACT_LEARN, 0, 0, 0, 0, 0, 0,
      0, 0, bgm_pkg::UPD_NONE},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_UPDATE, 16'd2, 200, 10, 0, 1, 32'd8,
      1, 0, bgm_pkg::UPD_LONG},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_UPDATE, 16'd2, 50, 60, 70, 1, 32'd6,
      1, 0, bgm_pkg::UPD_SHORT},
    '{1, bgm_pkg::REG_SHORT_PERIOD, 16'd0, bgm_pkg::ACT_LEARN, 0, 0, 0, 0, 0, 0,
      0, 0, bgm_pkg::UPD_NONE},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_UPDATE, 16'd2, 50, 60, 70, 0, 32'd6,
      1, 0, bgm_pkg::UPD_NONE},
    '{0, bgm_pkg::REG_LEARN_FRAMES, 0, bgm_pkg::ACT_SEGMENT, 16'd2, 33, 44, 55, 0, 32'd0,
      0, 0, bgm_pkg::UPD_NONE}
  };

  function automatic longint unsigned blend_val(longint unsigned old, longint unsigned tgt);
    return (old * (65536 - alpha_sh) + tgt * alpha_sh + 32768) >> 16;
  endfunction

  // advances the model memories by one item and returns its result
  function automatic bgm_pkg::out_item_t predict_pixel(bgm_pkg::in_item_t it);
    bgm_pkg::out_item_t res;
    int base;
    longint unsigned p, s, q, n, m, a, b, v, iq, d, k2;
    logic [7:0] px[3];
    bit wr;
    res = '0;
    wr = 1'b0;
    px[0] = it.red;
    px[1] = it.green;
    px[2] = it.blue;
    base = int'(it.pixel_index) * 3;
    case (it.action)
      bgm_pkg::ACT_LEARN: begin
        learned[it.pixel_index] = 1'b1;
        for (int c = 0; c < 3; c++) begin
          p = 64'(px[c]);
          if (it.frame_number == 0) begin
            mean_mem[base + c] = p;
            var_mem[base + c] = p * p;
          end else begin
            s = mean_mem[base + c] + p;
            q = var_mem[base + c] + p * p;
            mean_mem[base + c] = (s > 64'hFFFFFF) ? 64'hFFFFFF : s;
            var_mem[base + c] = (q > 64'h3FFFFFF) ? 64'h3FFFFFF : q;
          end
        end
      end
      bgm_pkg::ACT_FINALIZE: begin
        n = (lf_sh != 0) ? 64'(lf_sh) : 64'd1;
        for (int c = 0; c < 3; c++) begin
          s = mean_mem[base + c];
          q = var_mem[base + c];
          m = (s << 16) / n;
          a = q * n;
          b = s * s;
          v = (a > b) ? ((a - b) << 10) / (n * n) : 0;
          mean_mem[base + c] = (m > 64'hFFFFFF) ? 64'hFFFFFF : m;
          var_mem[base + c] = (v > 64'h3FFFFFF) ? 64'h3FFFFFF : v;
        end
      end
      bgm_pkg::ACT_SEGMENT: begin
        k2 = 64'(k_sh) * 64'(k_sh);
        for (int c = 0; c < 3; c++) begin
          m = mean_mem[base + c];
          iq = 64'(px[c]) << 16;
          d = (m > iq) ? m - iq : iq - m;
          if (((d * d) << 2) >= k2 * var_mem[base + c]) res.foreground = 1'b1;
        end
      end
      default: begin
        if (long_sh != 0 && 64'(it.frame_number) % 64'(long_sh) == 0) begin
          res.update_kind = bgm_pkg::UPD_LONG;
          wr = 1'b1;
        end else if (short_sh != 0 && 64'(it.frame_number) % 64'(short_sh) == 0) begin
          res.update_kind = bgm_pkg::UPD_SHORT;
          wr = !it.mask_bit;
        end
        if (wr) begin
          for (int c = 0; c < 3; c++) begin
            p = 64'(px[c]);
            mean_mem[base + c] = blend_val(mean_mem[base + c], p << 16);
            var_mem[base + c] = blend_val(var_mem[base + c], (p * p) << 10);
          end
        end
      end
    endcase
    return res;
  endfunction

  // send one item; valid stays high after acceptance until the next drive
  task automatic send_item(bgm_pkg::in_item_t it, bit typed, bgm_pkg::out_item_t typed_res);
    bgm_pkg::out_item_t exp_res;
    int gap;
    gap = (!calm && $urandom_range(99) < 33) ? int'($urandom_range(1, 4)) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_if.valid = 1'b0;
    end
    @(negedge clk);
    in_if.valid = 1'b1;
    in_if.payload = it;
    do @(posedge clk); while (!in_if.ready);
    exp_res = predict_pixel(it);
    pending_results.push_back(typed ? typed_res : exp_res);
    n_items++;
  endtask

  // drop valid and wait for every result, then for the block to settle
  task automatic drain;
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(bgm_pkg::cfg_reg_e idx, logic [15:0] val);
    drain();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      bgm_pkg::REG_LEARN_FRAMES: lf_sh = 32'(val[9:0]);
      bgm_pkg::REG_K_FACTOR:     k_sh = 32'(val);
      bgm_pkg::REG_ALPHA_WEIGHT: alpha_sh = 32'(val);
      bgm_pkg::REG_SHORT_PERIOD: short_sh = 32'(val);
      default:                   long_sh = 32'(val);
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_all(logic [15:0] lf, logic [15:0] kf, logic [15:0] al,
                         logic [15:0] sp, logic [15:0] lp);
    write_reg(bgm_pkg::REG_LEARN_FRAMES, lf);
    write_reg(bgm_pkg::REG_K_FACTOR, kf);
    write_reg(bgm_pkg::REG_ALPHA_WEIGHT, al);
    write_reg(bgm_pkg::REG_SHORT_PERIOD, sp);
    write_reg(bgm_pkg::REG_LONG_PERIOD, lp);
    n_settings++;
  endtask

  function automatic logic [31:0] pick_frame();
    case ($urandom_range(3))
      0: return $urandom;
      1: return short_sh * $urandom_range(5000);
      2: return long_sh * $urandom_range(5000);
      default: return $urandom_range(15);
    endcase
  endfunction

  function automatic logic [7:0] near(logic [7:0] base);
    int v;
    v = int'(base) + int'($urandom_range(8)) - 4;
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
  endfunction

  task automatic send_rand(bgm_pkg::action_e act, logic [15:0] pix, logic [7:0] r,
                           logic [7:0] g, logic [7:0] b, logic [31:0] frame);
    bgm_pkg::in_item_t it;
    it.action = act;
    it.pixel_index = pix;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.mask_bit = 1'($urandom_range(1));
    it.frame_number = frame;
    send_item(it, 1'b0, '0);
  endtask

  task automatic run_random(int unsigned count, bit pause_mid);
    int unsigned start, len;
    logic [15:0] pix;
    logic [7:0] r, g, b;
    bgm_pkg::action_e act;
    bit paused;
    start = n_items;
    paused = 1'b0;
    while (n_items - start < count) begin
      pix = pix_pool[4'($urandom_range(15))];
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      if (pause_mid && !paused && n_items - start > count / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 70) begin
        // learn a short frame sequence, finalize, then segment or update at random
        len = $urandom_range(1, 5);
        for (int f = 0; f < len; f++)
          send_rand(bgm_pkg::ACT_LEARN, pix, near(r), near(g), near(b), 32'(f));
        send_rand(bgm_pkg::ACT_FINALIZE, pix, 8'($urandom), 8'($urandom), 8'($urandom),
                  $urandom);
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(1))
            send_rand(bgm_pkg::ACT_SEGMENT, pix, $urandom_range(1) ? near(r) : 8'($urandom),
                      near(g), $urandom_range(1) ? near(b) : 8'($urandom), $urandom);
          else
            send_rand(bgm_pkg::ACT_UPDATE, pix, near(r), 8'($urandom), near(b), pick_frame());
        end
      end else begin
        act = bgm_pkg::action_e'($urandom_range(3));
        // never touch a pixel whose stores were never written
        if (!learned.exists(pix))
          send_rand(bgm_pkg::ACT_LEARN, pix, r, g, b, 32'd0);
        else
          send_rand(act, pix, r, g, b, (act == bgm_pkg::ACT_UPDATE) ? pick_frame() : $urandom);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    bgm_pkg::out_item_t exp_res;
    if (rst_n && out_if.valid && out_if.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result fg=%0b kind=%0d", $time,
                 out_if.payload.foreground, out_if.payload.update_kind);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_if.payload.foreground !== exp_res.foreground) begin
          $display("%0t: foreground expected %0b actual %0b", $time,
                   exp_res.foreground, out_if.payload.foreground);
          errors++;
        end
        if (out_if.payload.update_kind !== exp_res.update_kind) begin
          $display("%0t: update_kind expected %0d actual %0d", $time,
                   exp_res.update_kind, out_if.payload.update_kind);
          errors++;
        end
        n_fg += 32'(out_if.payload.foreground);
        if (out_if.payload.update_kind == bgm_pkg::UPD_SHORT) n_short++;
        if (out_if.payload.update_kind == bgm_pkg::UPD_LONG) n_long++;
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready = 1'b0;
        repeat (400) @(negedge clk);
      end
      out_if.ready = calm ? 1'b1 : ($urandom_range(99) >= 33);
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("%0t: no progress, %0d results outstanding", $time, pending_results.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    bgm_pkg::out_item_t typed_res;
    bgm_pkg::in_item_t it;
    clk = 1'b0;
    rst_n = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_fg = 0;
    n_short = 0;
    n_long = 0;
    n_settings = 1;
    lf_sh = 32'(bgm_pkg::LF_RESET);
    k_sh = 32'(bgm_pkg::K_RESET);
    alpha_sh = 32'(bgm_pkg::ALPHA_RESET);
    short_sh = 32'(bgm_pkg::SHORT_RESET);
    long_sh = 32'(bgm_pkg::LONG_RESET);
    pix_pool[0] = 16'd0;
    pix_pool[1] = 16'hFFFF;
    for (int i = 2; i < 16; i++) pix_pool[i] = 16'($urandom_range(65535));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        write_reg(dir_tab[i].reg_idx, dir_tab[i].value);
      end else begin
        it.action = dir_tab[i].act;
        it.pixel_index = dir_tab[i].pix;
        it.red = dir_tab[i].r;
        it.green = dir_tab[i].g;
        it.blue = dir_tab[i].b;
        it.mask_bit = dir_tab[i].mask;
        it.frame_number = dir_tab[i].frame;
        typed_res.foreground = dir_tab[i].fg;
        typed_res.update_kind = dir_tab[i].kind;
        send_item(it, dir_tab[i].typed, typed_res);
      end
    end

    set_all(16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(PHASE_ITEMS, 1'b0);
    set_all(16'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(PHASE_ITEMS, 1'b0);
    set_all(16'($urandom_range(1, 8)), 16'($urandom_range(16384)), 16'($urandom),
            16'($urandom_range(1, 4)), 16'($urandom_range(9)));
    hold_req = 1'b1;
    run_random(PHASE_ITEMS, 1'b0);
    set_all(16'($urandom_range(1, 1023)), 16'($urandom), 16'($urandom),
            16'($urandom_range(1, 3)), 16'($urandom_range(2, 6)));
    calm = 1'b1;
    run_random(PHASE_ITEMS / 2, 1'b0);
    calm = 1'b0;
    run_random(PHASE_ITEMS / 2, 1'b0);
    set_all(16'd0, 16'($urandom_range(8192)), 16'($urandom), 16'($urandom_range(1, 2)),
            16'($urandom_range(1, 5)));
    run_random(PHASE_ITEMS, 1'b1);

    drain();
    $display("Run covered %0d items and %0d results over %0d register settings:",
             n_items, n_results, n_settings);
    $display("  %0d foreground, %0d masked and %0d full updates, %0d mismatches",
             n_fg, n_short, n_long, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
